FILE: design/spv_pkg.sv
// shared types, register map and helpers for the sample playback voice
`timescale 1ns / 1ps
package spv_pkg;

    localparam int DEFAULT_SAMPLE_DEPTH = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAME_BITS = 13;
    localparam int MAG_BITS = SAMPLE_BITS + 1;
    localparam int GAIN_BITS = 16;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
    localparam logic [2:0] REG_STEREO      = 3'd1;
    localparam logic [2:0] REG_LOOP        = 3'd2;
    localparam logic [2:0] REG_LEFT_GAIN   = 3'd3;
    localparam logic [2:0] REG_RIGHT_GAIN  = 3'd4;
    localparam logic [2:0] REG_FADE_IN     = 3'd5;
    localparam logic [2:0] REG_FADE_OUT    = 3'd6;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'h8000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [11:0]        load_address;
        logic signed [15:0] load_left;
        logic signed [15:0] load_right;
    } req_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               frame_valid;
        logic               still_playing;
    } rsp_t;

    // operands for one scaled channel
    typedef struct packed {
        logic [MAG_BITS-1:0]   mag;
        logic                  neg;
        logic [GAIN_BITS-1:0]  gain;
        logic [FRAME_BITS-1:0] nin;
        logic [FRAME_BITS-1:0] nout;
        logic [FRAME_BITS-1:0] din;
        logic [FRAME_BITS-1:0] dout;
    } scl_op_t;

    // rounded magnitude to signed output with saturation
    function automatic logic [15:0] sat_out(input logic neg, input logic big,
                                            input logic [15:0] q);
        logic [15:0] r;
        begin
            if (neg) begin
                if (big || q > 16'd32768)
                    r = 16'h8000;
                else
                    r = 16'(~q + 16'd1);
            end
            else begin
                if (big || q > 16'd32767)
                    r = 16'h7fff;
                else
                    r = q;
            end
            return r;
        end
    endfunction

endpackage

FILE: design/spv_scaler.sv
// iterative scale unit: s2 * gain * fades / (den * 65536), rounded and saturated
`timescale 1ns / 1ps
module spv_scaler (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  spv_pkg::scl_op_t op,
    output logic            done,
    output logic [15:0]     result
);

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_ADD, S_CMP, S_DIV
    } state_t;

    state_t           state_reg;
    spv_pkg::scl_op_t op_reg;
    logic [58:0]      acc_reg;
    logic [25:0]      d_reg;
    logic [43:0]      y_reg;
    logic [25:0]      rem_reg;
    logic [15:0]      ylo_reg;
    logic [15:0]      q_reg;
    logic [3:0]       cnt_reg;
    logic             done_reg;
    logic [15:0]      result_reg;

    logic [42:0] mul_a;
    logic [15:0] mul_b;
    logic [58:0] prod;
    logic [59:0] sum;
    logic [26:0] trial;
    logic [26:0] diff;
    logic        ge;
    logic [25:0] rem_next;
    logic [15:0] q_next;

    // the one shared multiplier
    always_comb
    begin
        case (state_reg)
            S_M0:
            begin
                mul_a = 43'(op_reg.mag);
                mul_b = 16'(op_reg.nin);
            end
            S_M1:
            begin
                mul_a = acc_reg[42:0];
                mul_b = 16'(op_reg.nout);
            end
            S_M2:
            begin
                mul_a = acc_reg[42:0];
                mul_b = op_reg.gain;
            end
            S_M3:
            begin
                mul_a = 43'(op_reg.din);
                mul_b = 16'(op_reg.dout);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = 59'(mul_a) * 59'(mul_b);
    // half of the denominator added for rounding, then the 2^16 part dropped
    assign sum      = {1'b0, acc_reg} + (60'(d_reg) << 15);
    assign trial    = {rem_reg, ylo_reg[15]};
    assign ge       = trial >= {1'b0, d_reg};
    assign diff     = trial - {1'b0, d_reg};
    assign rem_next = ge ? diff[25:0] : trial[25:0];
    assign q_next   = {q_reg[14:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= op;
                        state_reg <= S_M0;
                    end
                end
                S_M0:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    d_reg     <= prod[25:0];
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    y_reg     <= sum[59:16];
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (y_reg >= 44'({d_reg, 16'h0000}))
                    begin
                        // quotient at least 65536: saturates either way
                        result_reg <= spv_pkg::sat_out(op_reg.neg, 1'b1, 16'h0000);
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        rem_reg   <= y_reg[41:16];
                        ylo_reg   <= y_reg[15:0];
                        q_reg     <= '0;
                        cnt_reg   <= 4'd15;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    ylo_reg <= {ylo_reg[14:0], 1'b0};
                    q_reg   <= q_next;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0)
                    begin
                        result_reg <= spv_pkg::sat_out(op_reg.neg, 1'b0, q_next);
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: design/sample_playback_voice.sv
// sample playback voice: sample memory, register file, tick sequencer
//
// Requests come in on req (req_valid / req_stall), one word per request:
// load writes one frame to the sample memory, start rewinds and plays,
// stop halts, tick produces one stereo frame. Only a tick gives a word on
// rsp (rsp_valid / rsp_stall). Registers are written over the APB port;
// the user must write them only while the voice is idle (not enforced).
// Load, start and stop leave the voice idle. A tick while stopped, or one
// that hits the end of the buffer without looping, goes straight to T_DONE
// and raises rsp_valid once the rsp register is free. A playing tick does
// one memory read, then the left and the right channel each pass through
// the shared scale unit (four multiplies, a round, a compare and, unless
// the result saturates, a 16-step restoring divide). req_stall is high
// while a tick is being worked, so the next request is taken in the cycle
// after the word is handed over.
// A finished word sits in the rsp register; the next request is taken
// meanwhile, and a following tick waits at its end until rsp is free.
// Reset restores register defaults, the playhead and playing flag; the
// sample memory is not cleared, frames must be loaded before playback.
`timescale 1ns / 1ps
module sample_playback_voice #(
    parameter int SAMPLE_DEPTH = spv_pkg::DEFAULT_SAMPLE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spv_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spv_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int NCAP = (SAMPLE_DEPTH < 8191) ? SAMPLE_DEPTH : 8191;
    localparam logic [12:0] NCAP_F = 13'(NCAP);

    typedef enum logic [2:0] {
        T_IDLE, T_READ, T_LSTART, T_LWAIT, T_RWAIT, T_DONE
    } state_t;

    logic [31:0] mem [SAMPLE_DEPTH];

    // configuration registers
    logic [12:0] frame_count_reg;
    logic        stereo_reg;
    logic        loop_reg;
    logic [15:0] left_gain_reg;
    logic [15:0] right_gain_reg;
    logic [12:0] fade_in_reg;
    logic [12:0] fade_out_reg;

    state_t        state_reg;
    logic [12:0]   playhead_reg;
    logic          playing_reg;
    logic [31:0]   rd_reg;
    logic [12:0]   nin_reg, din_reg, nout_reg, dout_reg;
    logic [16:0]   mag_reg;
    logic          neg_reg;
    logic [15:0]   left_reg;
    spv_pkg::rsp_t res_reg;
    logic          rsp_valid_reg;
    spv_pkg::rsp_t rsp_reg;

    logic        accept;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [12:0] n;
    logic        at_end;
    logic        wrap;
    logic [12:0] p;
    logic [13:0] p_plus_fo;
    logic [31:0] wide_load;
    logic [31:0] wide_p;
    logic [17:0] s2;
    logic        out_free;

    spv_pkg::scl_op_t scl_op;
    logic             scl_start;
    logic             scl_done;
    logic [15:0]      scl_result;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != T_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_comb
    begin
        case (cfg_idx)
            spv_pkg::REG_FRAME_COUNT: prdata = 32'(frame_count_reg);
            spv_pkg::REG_STEREO:      prdata = 32'(stereo_reg);
            spv_pkg::REG_LOOP:        prdata = 32'(loop_reg);
            spv_pkg::REG_LEFT_GAIN:   prdata = 32'(left_gain_reg);
            spv_pkg::REG_RIGHT_GAIN:  prdata = 32'(right_gain_reg);
            spv_pkg::REG_FADE_IN:     prdata = 32'(fade_in_reg);
            spv_pkg::REG_FADE_OUT:    prdata = 32'(fade_out_reg);
            default:                  prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            stereo_reg      <= 1'b0;
            loop_reg        <= 1'b0;
            left_gain_reg   <= spv_pkg::GAIN_RESET;
            right_gain_reg  <= spv_pkg::GAIN_RESET;
            fade_in_reg     <= '0;
            fade_out_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                spv_pkg::REG_FRAME_COUNT: frame_count_reg <= pwdata[12:0];
                spv_pkg::REG_STEREO:      stereo_reg      <= pwdata[0];
                spv_pkg::REG_LOOP:        loop_reg        <= pwdata[0];
                spv_pkg::REG_LEFT_GAIN:   left_gain_reg   <= pwdata[15:0];
                spv_pkg::REG_RIGHT_GAIN:  right_gain_reg  <= pwdata[15:0];
                spv_pkg::REG_FADE_IN:     fade_in_reg     <= pwdata[12:0];
                spv_pkg::REG_FADE_OUT:    fade_out_reg    <= pwdata[12:0];
                default:                  ;
            endcase
        end
    end

    // playhead handling for a tick
    assign n         = (frame_count_reg > NCAP_F) ? NCAP_F : frame_count_reg;
    assign at_end    = playhead_reg >= n;
    assign wrap      = at_end && loop_reg && (n != 13'd0);
    assign p         = wrap ? 13'd0 : playhead_reg;
    assign p_plus_fo = {1'b0, p} + {1'b0, fade_out_reg};
    assign wide_load = 32'(req.load_address);
    assign wide_p    = 32'(p);

    // sample memory
    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == spv_pkg::REQ_LOAD && wide_load < 32'(SAMPLE_DEPTH))
            mem[wide_load[AW-1:0]] <= {req.load_left, req.load_right};
    end

    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == spv_pkg::REQ_TICK)
            rd_reg <= mem[wide_p[AW-1:0]];
    end

    // left + right, or twice the mono sample
    assign s2 = stereo_reg
        ? (18'(signed'(rd_reg[31:16])) + 18'(signed'(rd_reg[15:0])))
        : {rd_reg[31], rd_reg[31:16], 1'b0};

    always_comb
    begin
        scl_op.mag  = mag_reg;
        scl_op.neg  = neg_reg;
        scl_op.gain = (state_reg == T_LSTART) ? left_gain_reg : right_gain_reg;
        scl_op.nin  = nin_reg;
        scl_op.nout = nout_reg;
        scl_op.din  = din_reg;
        scl_op.dout = dout_reg;
    end

    assign scl_start = (state_reg == T_LSTART) || (state_reg == T_LWAIT && scl_done);

    spv_scaler u_scaler (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scl_start),
        .op     (scl_op),
        .done   (scl_done),
        .result (scl_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            playhead_reg  <= '0;
            playing_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // in T_DONE the rsp register is reloaded below instead
            if (rsp_valid_reg && !rsp_stall && state_reg != T_DONE)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.req_type)
                            spv_pkg::REQ_START:
                            begin
                                playhead_reg <= '0;
                                playing_reg  <= 1'b1;
                            end
                            spv_pkg::REQ_STOP:
                            begin
                                playing_reg <= 1'b0;
                            end
                            spv_pkg::REQ_TICK:
                            begin
                                res_reg <= '0;
                                if (!playing_reg)
                                begin
                                    state_reg <= T_DONE;
                                end
                                else if (at_end && !wrap)
                                begin
                                    playing_reg <= 1'b0;
                                    state_reg   <= T_DONE;
                                end
                                else
                                begin
                                    playhead_reg <= p + 13'd1;
                                    if (fade_in_reg != 13'd0 && p < fade_in_reg)
                                    begin
                                        nin_reg <= p;
                                        din_reg <= fade_in_reg;
                                    end
                                    else
                                    begin
                                        nin_reg <= 13'd1;
                                        din_reg <= 13'd1;
                                    end
                                    if (fade_out_reg != 13'd0 && p_plus_fo >= {1'b0, n})
                                    begin
                                        nout_reg <= n - p;
                                        dout_reg <= fade_out_reg;
                                    end
                                    else
                                    begin
                                        nout_reg <= 13'd1;
                                        dout_reg <= 13'd1;
                                    end
                                    state_reg <= T_READ;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                T_READ:
                begin
                    neg_reg   <= s2[17];
                    mag_reg   <= s2[17] ? 17'(-s2) : s2[16:0];
                    state_reg <= T_LSTART;
                end
                T_LSTART:
                begin
                    state_reg <= T_LWAIT;
                end
                T_LWAIT:
                begin
                    if (scl_done)
                    begin
                        left_reg  <= scl_result;
                        state_reg <= T_RWAIT;
                    end
                end
                T_RWAIT:
                begin
                    if (scl_done)
                    begin
                        res_reg.left_out      <= left_reg;
                        res_reg.right_out     <= scl_result;
                        res_reg.frame_valid   <= 1'b1;
                        res_reg.still_playing <= 1'b1;
                        state_reg             <= T_DONE;
                    end
                end
                T_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: design/spv_checker.sv
// port-level checks for the sample playback voice, bound to the top level
`timescale 1ns / 1ps
module spv_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input spv_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input spv_pkg::rsp_t rsp,
    input logic          pready
);

    // a waiting word is not dropped
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("rsp word dropped while stalled");

    a_silence: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.frame_valid |->
            rsp.left_out == 16'sd0 && rsp.right_out == 16'sd0 && !rsp.still_playing)
        else $error("silent word with nonzero payload");

    a_played: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.frame_valid |-> rsp.still_playing)
        else $error("played frame without playing flag");

    // an accepted tick always raises req_stall in the following cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.req_type == spv_pkg::REQ_TICK |=> req_stall)
        else $error("tick accepted without going busy");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind sample_playback_voice spv_checker u_spv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .pready    (pready)
);

FILE: dv/tb_sample_playback_voice.sv
// testbench for the sample playback voice: scoreboard, stimulus and checks
`timescale 1ns / 1ps
module tb_sample_playback_voice;

    class voice_scoreboard;
        logic [31:0] frames [4096];
        logic [12:0] playhead;
        bit          playing;
        logic [12:0] frame_count;
        bit          stereo;
        bit          looping;
        logic [15:0] left_gain;
        logic [15:0] right_gain;
        logic [12:0] fade_in;
        logic [12:0] fade_out;
        spv_pkg::rsp_t frames_due [$];
        int          mismatches;

        function new();
            playhead = '0;
            playing = 0;
            frame_count = '0;
            stereo = 0;
            looping = 0;
            left_gain = spv_pkg::GAIN_RESET;
            right_gain = spv_pkg::GAIN_RESET;
            fade_in = '0;
            fade_out = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                spv_pkg::REG_FRAME_COUNT: frame_count = v[12:0];
                spv_pkg::REG_STEREO:      stereo = v[0];
                spv_pkg::REG_LOOP:        looping = v[0];
                spv_pkg::REG_LEFT_GAIN:   left_gain = v[15:0];
                spv_pkg::REG_RIGHT_GAIN:  right_gain = v[15:0];
                spv_pkg::REG_FADE_IN:     fade_in = v[12:0];
                spv_pkg::REG_FADE_OUT:    fade_out = v[12:0];
                default: ;
            endcase
        endfunction

        // exact product, round half away from zero, saturate
        function logic [15:0] scaled(longint s2, longint unsigned num,
                                     longint unsigned den);
            longint unsigned mag;
            longint q;
            mag = longint'(s2 < 0 ? -s2 : s2) * num;
            q = longint'((mag + den / 2) / den);
            if (s2 < 0)
                q = -q;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[15:0];
        endfunction

        function spv_pkg::rsp_t play_tick();
            spv_pkg::rsp_t o;
            int n, p;
            longint l, r, s2;
            longint unsigned nin, din, nout, dout, den;
            o = '0;
            nin = 1; din = 1; nout = 1; dout = 1;
            if (!playing)
                return o;
            n = (frame_count > 4096) ? 4096 : frame_count;
            if (playhead >= n)
            begin
                if (looping && n > 0)
                    playhead = '0;
                else
                begin
                    playing = 0;
                    return o;
                end
            end
            p = playhead;
            l = longint'($signed(frames[p][31:16]));
            r = longint'($signed(frames[p][15:0]));
            s2 = stereo ? l + r : 2 * l;
            if (fade_in > 0 && p < fade_in)
            begin
                nin = p;
                din = fade_in;
            end
            if (fade_out > 0 && p + fade_out >= n)
            begin
                nout = n - p;
                dout = fade_out;
            end
            den = din * dout * 65536;
            o.left_out = scaled(s2, nin * nout * left_gain, den);
            o.right_out = scaled(s2, nin * nout * right_gain, den);
            o.frame_valid = 1;
            o.still_playing = 1;
            playhead = 13'(p + 1);
            return o;
        endfunction

        function void note_request(spv_pkg::req_t q);
            case (q.req_type)
                spv_pkg::REQ_LOAD:  frames[q.load_address] = {q.load_left, q.load_right};
                spv_pkg::REQ_START:
                begin
                    playhead = '0;
                    playing = 1;
                end
                spv_pkg::REQ_STOP:  playing = 0;
                default:            frames_due.push_back(play_tick());
            endcase
        endfunction

        function void check_frame(spv_pkg::rsp_t got);
            spv_pkg::rsp_t want;
            if (frames_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", got);
                return;
            end
            want = frames_due.pop_front();
            if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
                got.frame_valid !== want.frame_valid ||
                got.still_playing !== want.still_playing)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp L=%0d R=%0d v=%b p=%b got L=%0d R=%0d v=%b p=%b",
                             want.left_out, want.right_out, want.frame_valid,
                             want.still_playing, got.left_out, got.right_out,
                             got.frame_valid, got.still_playing);
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    spv_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    spv_pkg::rsp_t rsp;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [4:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    voice_scoreboard sb;
    int hold_off;
    int random_sent;

    sample_playback_voice dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // receiver stall pattern, with an occasional long hold-off
    initial
    begin
        rsp_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                rsp_stall <= 1;
                hold_off--;
            end
            else if (($urandom_range(0, 63) < 32) && ($urandom_range(0, 3) == 0))
                rsp_stall <= 1;
            else
                rsp_stall <= ($urandom_range(0, 9) < 2);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_frame(rsp);

    task automatic send_word(spv_pkg::req_t q);
        @(negedge clk);
        req_valid <= 1;
        req <= q;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(q);
    endtask

    task automatic idle_sender(int cycles);
        @(negedge clk);
        req_valid <= 0;
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
    endtask

    // wait for every expected word, then for the block to settle
    task automatic drain();
        idle_sender(1);
        while (sb.frames_due.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    function automatic spv_pkg::req_t mk(logic [1:0] t, logic [11:0] a = 12'd0,
                                         logic [15:0] l = 16'd0, logic [15:0] r = 16'd0);
        spv_pkg::req_t q;
        q.req_type = t;
        q.load_address = a;
        q.load_left = l;
        q.load_right = r;
        return q;
    endfunction

    task automatic configure(int n, bit st, bit lp, int lg, int rg, int fi, int fo);
        write_reg(spv_pkg::REG_FRAME_COUNT, 32'(n));
        write_reg(spv_pkg::REG_STEREO, 32'(st));
        write_reg(spv_pkg::REG_LOOP, 32'(lp));
        write_reg(spv_pkg::REG_LEFT_GAIN, 32'(lg));
        write_reg(spv_pkg::REG_RIGHT_GAIN, 32'(rg));
        write_reg(spv_pkg::REG_FADE_IN, 32'(fi));
        write_reg(spv_pkg::REG_FADE_OUT, 32'(fo));
    endtask

    task automatic random_phase(int count);
        int burst;
        spv_pkg::req_t q;
        int pick;
        burst = $urandom_range(1, 8);
        send_word(mk(spv_pkg::REQ_START));
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                q = mk(spv_pkg::REQ_TICK, 12'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 80)
                q = mk(spv_pkg::REQ_START, 12'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 88)
                q = mk(spv_pkg::REQ_STOP, 12'($urandom), 16'($urandom), 16'($urandom));
            else
                q = mk(spv_pkg::REQ_LOAD, 12'($urandom), 16'($urandom), 16'($urandom));
            send_word(q);
            random_sent++;
            burst--;
            if (burst == 0)
            begin
                idle_sender($urandom_range(1, 6));
                burst = $urandom_range(1, 8);
            end
        end
    endtask

    initial
    begin
        int n, fi, fo, lg, rg;
        sb = new();
        hold_off = 0;
        random_sent = 0;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // the playhead never passes frame 63, so only those frames are filled
        for (int a = 0; a < 64; a++)
            send_word(mk(spv_pkg::REQ_LOAD, 12'(a), 16'($urandom), 16'($urandom)));
        send_word(mk(spv_pkg::REQ_LOAD, 12'd0, 16'h8000, 16'h8000));
        send_word(mk(spv_pkg::REQ_LOAD, 12'd1, 16'h7fff, 16'h7fff));
        send_word(mk(spv_pkg::REQ_LOAD, 12'd2, 16'h8000, 16'h7fff));
        send_word(mk(spv_pkg::REQ_LOAD, 12'd3, 16'h0000, 16'hffff));

        // directed: silent tick, saturation, stop, end without loop
        send_word(mk(spv_pkg::REQ_TICK));
        drain();
        configure(4, 0, 0, 65535, 0, 0, 0);
        send_word(mk(spv_pkg::REQ_START));
        repeat (5)
            send_word(mk(spv_pkg::REQ_TICK));
        send_word(mk(spv_pkg::REQ_START));
        send_word(mk(spv_pkg::REQ_TICK));
        send_word(mk(spv_pkg::REQ_STOP));
        send_word(mk(spv_pkg::REQ_TICK));
        drain();
        // empty buffer while looping
        configure(0, 1, 1, 32768, 65535, 0, 0);
        send_word(mk(spv_pkg::REQ_START));
        send_word(mk(spv_pkg::REQ_TICK));
        send_word(mk(spv_pkg::REQ_TICK));
        drain();
        // wrap with both fades
        configure(3, 1, 1, 40000, 20000, 2, 2);
        send_word(mk(spv_pkg::REQ_START));
        repeat (7)
            send_word(mk(spv_pkg::REQ_TICK));
        drain();
        // large count, clamped to the memory depth, fades over the whole buffer
        configure(8191, 0, 0, 65535, 65535, 4096, 4096);
        send_word(mk(spv_pkg::REQ_START));
        repeat (4)
            send_word(mk(spv_pkg::REQ_TICK));
        drain();

        // long receiver hold-off while ticks keep coming
        configure(6, 1, 1, 32768, 32768, 3, 2);
        hold_off = 400;
        random_phase(30);
        drain();

        while (random_sent < 300)
        begin
            case ($urandom_range(0, 9))
                0: n = 0;
                1: n = 4096;
                default: n = $urandom_range(1, 40);
            endcase
            fi = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, n + 3);
            fo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, n + 3);
            if ($urandom_range(0, 9) == 0)
                fo = 4096;
            lg = ($urandom_range(0, 4) == 0) ? 65535 * $urandom_range(0, 1)
                                             : $urandom_range(0, 65535);
            rg = ($urandom_range(0, 4) == 0) ? 65535 * $urandom_range(0, 1)
                                             : $urandom_range(0, 65535);
            configure(n, $urandom_range(0, 1), $urandom_range(0, 1), lg, rg, fi, fo);
            random_phase($urandom_range(20, 60));
            drain();
        end

        if (sb.mismatches == 0 && sb.frames_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
